// ===== rtl/trm_pkg.sv =====
// Shared types, constants and helper functions for the transfer rate monitor.
`default_nettype none

package trm_pkg;

   // Field widths
   localparam int TIME_W     = 40;
   localparam int BYTE_W     = 48;
   localparam int CNT_IN_W   = 49;
   localparam int RATE_W     = 56;
   localparam int SUM_W      = 64;
   localparam int PCT_W      = 25;
   localparam int SAMP_W     = 32;
   localparam int INTV_W     = 12;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 48;
   localparam int SQ_HALF_W  = 28;
   localparam int SQ_W       = 2 * RATE_W;

   // Divider sizing: 49-bit byte count times 256e6 over a 48-bit divisor
   localparam int DIV_N_W = 77;
   localparam int DIV_D_W = 48;
   localparam int DIV_C_W = $clog2(DIV_N_W + 1);

   localparam int HISTORY_DEPTH_DEF = 16;

   // Constants
   localparam logic [TIME_W-1:0] HOLD_US     = TIME_W'(10000);
   localparam logic [19:0]       US_PER_S    = 20'd1000000;
   localparam logic [14:0]       PCT_SCALE   = 15'd25600;
   localparam logic [RATE_W-1:0] RATE_MAX    = {RATE_W{1'b1}};
   localparam logic [SUM_W-1:0]  SUM_MAX     = {SUM_W{1'b1}};
   localparam logic [SAMP_W-1:0] SAMP_MAX    = {SAMP_W{1'b1}};
   localparam logic [BYTE_W-1:0] BYTE_MAX    = {BYTE_W{1'b1}};
   localparam logic [PCT_W-1:0]  PCT_CAP     = PCT_W'(25600000);
   localparam logic [PCT_W:0]    WRAP_LIMIT  = (PCT_W + 1)'(50944);
   localparam logic [PCT_W:0]    WRAP_STEP   = (PCT_W + 1)'(512);

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BITS_MODE    = 8'd0,
      CSR_SNAP_INTV    = 8'd1,
      CSR_TOTAL_SIZE   = 8'd2,
      CSR_START_OFFSET = 8'd3
   } csr_index_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_RATE,
      S_MDIV,
      S_SQ,
      S_WIN,
      S_WHEAD,
      S_WDIV,
      S_FIN,
      S_FDIV,
      S_PCT,
      S_PDIV,
      S_DONE
   } trm_state_type;

   // Divider command and status
   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_sts_type;

   // Bytes times 256e6: Q8 bytes per second once divided by microseconds
   function automatic logic [DIV_N_W-1:0] q8_scale(input logic [CNT_IN_W-1:0] b);
      logic [CNT_IN_W+19:0] p;
      p = (CNT_IN_W + 20)'(b) * (CNT_IN_W + 20)'(US_PER_S);
      return {p, 8'b0};
   endfunction

   // Byte count times 25600 for the known-size percentage
   function automatic logic [DIV_N_W-1:0] pct_scale(input logic [BYTE_W-1:0] b);
      return DIV_N_W'(b) * DIV_N_W'(PCT_SCALE);
   endfunction

   function automatic logic [RATE_W-1:0] sat_rate(input logic [DIV_N_W-1:0] q);
      return (q > DIV_N_W'(RATE_MAX)) ? RATE_MAX : q[RATE_W-1:0];
   endfunction

   function automatic logic [SUM_W-1:0] sat_add64(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/trm_if.sv =====
// Channel interfaces: update requests, results and register writes.
`default_nettype none

interface trm_req_if;
   import trm_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [TIME_W-1:0]          elapsed_us;
   logic signed [CNT_IN_W-1:0] byte_count;
   logic                       is_final;

   modport source (output valid, elapsed_us, byte_count, is_final, input ready);
   modport sink   (input valid, elapsed_us, byte_count, is_final, output ready);
endinterface

interface trm_rsp_if;
   import trm_pkg::*;
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] current_rate;
   logic [RATE_W-1:0] window_rate;
   logic [PCT_W-1:0]  percent_done;
   logic [RATE_W-1:0] min_rate;
   logic [RATE_W-1:0] max_rate;
   logic [SUM_W-1:0]  rate_total;
   logic [SUM_W-1:0]  rate_square_total;
   logic [SAMP_W-1:0] sample_count;

   modport source (output valid, current_rate, window_rate, percent_done, min_rate,
                   max_rate, rate_total, rate_square_total, sample_count, input ready);
   modport sink   (input valid, current_rate, window_rate, percent_done, min_rate,
                   max_rate, rate_total, rate_square_total, sample_count, output ready);
endinterface

interface trm_csr_if;
   import trm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/trm_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module trm_div (
   input  wire                 clock,
   input  wire                 reset,
   input  trm_pkg::div_req_type div_req,
   output trm_pkg::div_sts_type div_sts
);
   import trm_pkg::*;

   logic               busy_ff;
   logic               done_ff;
   logic [DIV_C_W-1:0] cnt_ff;
   logic [DIV_D_W-1:0] rem_ff;
   logic [DIV_N_W-1:0] quo_ff;
   logic [DIV_D_W-1:0] dvs_ff;

   logic [DIV_D_W:0]   shifted;
   logic [DIV_D_W:0]   diff;
   logic               ge;
   logic [DIV_D_W-1:0] rem_in;

   // Trial subtract of the shifted remainder
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_N_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = (shifted >= {1'b0, dvs_ff});
      rem_in  = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_C_W'(DIV_N_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_C_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         dvs_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DIV_N_W-2:0], ge};
      end
   end

   assign div_sts.busy     = busy_ff;
   assign div_sts.done     = done_ff;
   assign div_sts.quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/transfer_rate_monitor.sv =====
// Transfer rate monitor top level: sequencer, statistics and snapshot ring.
//
//   channel  dir  handshake           payload
//   req_bus  in   valid/ready         elapsed_us, byte_count, is_final
//   rsp_bus  out  valid/ready         rates, percent, min/max, totals, count
//   csr_bus  in   valid/ready (=1)    index, data
//
// One request at a time. Each division a request needs (rate measurement,
// window average, final average, known-size percentage) runs on the shared
// bit-serial divider; squaring uses a 28x28 multiplier. Synchronous reset
// clears the sequencer, configuration, statistics and ring valid bits, not
// the ring memory or working registers; each ring entry has a valid bit.
// A result waits in the output register while the next request is taken.
`default_nettype none

module transfer_rate_monitor #(
   parameter int HISTORY_DEPTH = trm_pkg::HISTORY_DEPTH_DEF
) (
   input wire     clock,
   input wire     reset,
   trm_req_if.sink   req_bus,
   trm_rsp_if.source rsp_bus,
   trm_csr_if.sink   csr_bus
);
   import trm_pkg::*;

   localparam int RING_AW = $clog2(HISTORY_DEPTH);
   localparam int ENTRY_W = TIME_W + BYTE_W;

   function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] p);
      return (p == RING_AW'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Sequencer
   trm_state_type state_ff, state_in;

   // Configuration
   logic              bits_mode_ff;
   logic [INTV_W-1:0] intv_ff;
   logic [BYTE_W-1:0] total_ff;
   logic [BYTE_W-1:0] offset_ff;

   // Latched request
   logic [TIME_W-1:0] now_ff;
   logic [BYTE_W-1:0] count_ff;
   logic              known_ff;
   logic              fin_ff;
   logic [BYTE_W-1:0] delta_ff;
   logic              hold_ff;

   // Running state
   logic [BYTE_W-1:0]  last_bytes_ff;
   logic [TIME_W-1:0]  last_time_ff;
   logic [BYTE_W-1:0]  pending_ff;
   logic [RATE_W-1:0]  last_rate_ff;
   logic [RATE_W-1:0]  min_ff;
   logic [RATE_W-1:0]  max_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [SUM_W-1:0]   sqsum_ff;
   logic [SAMP_W-1:0]  samples_ff;
   logic [RING_AW-1:0] head_ff;
   logic [RING_AW-1:0] tail_ff;
   logic [RATE_W-1:0]  avg_held_ff;
   logic [PCT_W-1:0]   pct_held_ff;

   // Working registers
   logic [RATE_W-1:0]    rate_out_ff;
   logic [RATE_W-1:0]    avg_out_ff;
   logic [RATE_W-1:0]    meas_ff;
   logic [2*SQ_HALF_W-1:0] mult_ff;
   logic [SQ_W-1:0]      acc_ff;
   logic [1:0]           sq_idx_ff;

   // Output register
   logic              rsp_valid_ff;
   logic [RATE_W-1:0] o_rate_ff, o_avg_ff, o_min_ff, o_max_ff;
   logic [PCT_W-1:0]  o_pct_ff;
   logic [SUM_W-1:0]  o_sum_ff, o_sqsum_ff;
   logic [SAMP_W-1:0] o_samples_ff;

   // Snapshot ring memory
   logic [ENTRY_W-1:0]       ring_mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] ring_vld_ff;
   logic [ENTRY_W-1:0]       rd_data_ff;
   logic                     rd_vld_ff;
   logic                     mem_we, mem_re;
   logic [RING_AW-1:0]       mem_waddr, mem_raddr;

   // Divider
   div_req_type div_req;
   div_sts_type div_sts;

   trm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts)
   );

   // Shared combinational terms
   logic                req_fire, rsp_free;
   logic [BYTE_W-1:0]   req_count;
   logic                hold_cmp;
   logic [BYTE_W:0]     pend_sum;
   logic [RATE_W-1:0]   rate_q, meas_q;
   logic [TIME_W-1:0]   prev_time, head_time;
   logic [BYTE_W-1:0]   head_bytes;
   logic [31:0]         intv_us;
   logic                win_skip, win_adv, win_bad;
   logic [RING_AW-1:0]  tail_n, head_n;
   logic [TIME_W-1:0]   win_span;
   logic                fin_bad;
   logic [SQ_HALF_W-1:0] sq_a, sq_b;
   logic [SQ_W-1:0]     acc_sum;
   logic [SUM_W-1:0]    sq_term;
   logic [PCT_W:0]      pct_wrap;
   logic [PCT_W-1:0]    pct_wrap_next;

   always_comb begin
      req_fire  = req_bus.valid && req_bus.ready;
      rsp_free  = !rsp_valid_ff || rsp_bus.ready;
      req_count = req_bus.byte_count[BYTE_W-1:0];
      hold_cmp  = ({1'b0, now_ff} <= ({1'b0, last_time_ff} + (TIME_W + 1)'(HOLD_US)));
      pend_sum  = {1'b0, delta_ff} + {1'b0, pending_ff};

      // Rate from the divider, and the tracked value
      rate_q = sat_rate(div_sts.quotient);
      if (bits_mode_ff) begin
         meas_q = (rate_q > (RATE_MAX >> 3)) ? RATE_MAX : {rate_q[RATE_W-4:0], 3'b000};
      end else begin
         meas_q = rate_q;
      end

      // Snapshot decision from the tail entry
      prev_time  = rd_vld_ff ? rd_data_ff[ENTRY_W-1:BYTE_W] : '0;
      head_time  = rd_vld_ff ? rd_data_ff[ENTRY_W-1:BYTE_W] : '0;
      head_bytes = rd_vld_ff ? rd_data_ff[BYTE_W-1:0] : '0;
      intv_us    = 32'(intv_ff) * 32'(US_PER_S);
      win_adv    = (prev_time != '0);
      win_skip   = win_adv && ({1'b0, now_ff} < ({1'b0, prev_time} + (TIME_W + 1)'(intv_us)));
      tail_n     = win_adv ? ring_inc(tail_ff) : tail_ff;
      head_n     = (win_adv && (tail_n == head_ff)) ? ring_inc(head_ff) : head_ff;
      win_bad    = (last_bytes_ff < head_bytes) || (now_ff < head_time);
      win_span   = now_ff - head_time;
      fin_bad    = !known_ff || (count_ff < offset_ff);

      // Squaring in three partial products
      unique case (sq_idx_ff)
         2'd0:    begin sq_a = meas_ff[SQ_HALF_W-1:0]; sq_b = meas_ff[SQ_HALF_W-1:0]; end
         2'd1:    begin sq_a = meas_ff[RATE_W-1:SQ_HALF_W]; sq_b = meas_ff[SQ_HALF_W-1:0]; end
         default: begin sq_a = meas_ff[RATE_W-1:SQ_HALF_W]; sq_b = meas_ff[RATE_W-1:SQ_HALF_W]; end
      endcase
      unique case (sq_idx_ff)
         2'd1:    acc_sum = acc_ff + SQ_W'(mult_ff);
         2'd2:    acc_sum = acc_ff + (SQ_W'(mult_ff) << (SQ_HALF_W + 1));
         2'd3:    acc_sum = acc_ff + (SQ_W'(mult_ff) << (2 * SQ_HALF_W));
         default: acc_sum = '0;
      endcase
      sq_term = (acc_sum[SQ_W-1:SUM_W+16] != '0) ? SUM_MAX : acc_sum[SUM_W+15:16];

      // Wrap-mode percentage
      pct_wrap      = {1'b0, pct_held_ff} + ((rate_out_ff != '0) ? WRAP_STEP : '0);
      pct_wrap_next = (pct_wrap > WRAP_LIMIT) ? '0 : pct_wrap[PCT_W-1:0];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_fire) state_in = S_PREP;
         S_PREP:  state_in = S_RATE;
         S_RATE:  state_in = hold_ff ? S_WIN : S_MDIV;
         S_MDIV:  if (div_sts.done) state_in = S_SQ;
         S_SQ:    if (sq_idx_ff == 2'd3) state_in = S_WIN;
         S_WIN: begin
            if (win_skip || (head_n == tail_n)) state_in = S_FIN;
            else state_in = S_WHEAD;
         end
         S_WHEAD: state_in = win_bad ? S_FIN : S_WDIV;
         S_WDIV:  if (div_sts.done) state_in = S_FIN;
         S_FIN:   state_in = (fin_ff && !fin_bad) ? S_FDIV : S_PCT;
         S_FDIV:  if (div_sts.done) state_in = S_PCT;
         S_PCT:   state_in = ((total_ff != '0) && known_ff) ? S_PDIV : S_DONE;
         S_PDIV:  if (div_sts.done) state_in = S_DONE;
         S_DONE:  if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs: memory access and divider commands
   always_comb begin
      mem_we           = 1'b0;
      mem_re           = 1'b0;
      mem_waddr        = tail_n;
      mem_raddr        = tail_ff;
      div_req.start    = 1'b0;
      div_req.dividend = q8_scale({1'b0, count_ff - offset_ff});
      div_req.divisor  = DIV_D_W'((now_ff == '0) ? TIME_W'(1) : now_ff);
      unique case (state_ff)
         S_PREP: mem_re = 1'b1;
         S_RATE: begin
            div_req.start    = !hold_ff;
            div_req.dividend = q8_scale(pend_sum);
            div_req.divisor  = DIV_D_W'(now_ff - last_time_ff);
         end
         S_WIN: begin
            mem_we    = !win_skip;
            mem_re    = !win_skip && (head_n != tail_n);
            mem_raddr = head_n;
         end
         S_WHEAD: begin
            div_req.start    = !win_bad;
            div_req.dividend = q8_scale({1'b0, last_bytes_ff - head_bytes});
            div_req.divisor  = DIV_D_W'((win_span == '0) ? TIME_W'(1) : win_span);
         end
         S_FIN: div_req.start = fin_ff && !fin_bad;
         S_PCT: begin
            div_req.start    = (total_ff != '0) && known_ff;
            div_req.dividend = pct_scale(count_ff);
            div_req.divisor  = total_ff;
         end
         default: ;
      endcase
   end

   // Ring memory
   always_ff @(posedge clock) begin
      if (mem_we) ring_mem[mem_waddr] <= {now_ff, last_bytes_ff};
      if (mem_re) begin
         rd_data_ff <= ring_mem[mem_raddr];
         rd_vld_ff  <= ring_vld_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff <= '0;
      end else if (mem_we) begin
         ring_vld_ff[mem_waddr] <= 1'b1;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_mode_ff <= 1'b0;
         intv_ff      <= INTV_W'(1);
         total_ff     <= '0;
         offset_ff    <= '0;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            CSR_BITS_MODE:    bits_mode_ff <= csr_bus.data[0];
            CSR_SNAP_INTV:    intv_ff      <= csr_bus.data[INTV_W-1:0];
            CSR_TOTAL_SIZE:   total_ff     <= csr_bus.data[BYTE_W-1:0];
            CSR_START_OFFSET: offset_ff    <= csr_bus.data[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // State register, statistics and per-request working values
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_bytes_ff <= '0;
         last_time_ff  <= '0;
         pending_ff    <= '0;
         last_rate_ff  <= '0;
         min_ff        <= '0;
         max_ff        <= '0;
         sum_ff        <= '0;
         sqsum_ff      <= '0;
         samples_ff    <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         avg_held_ff   <= '0;
         pct_held_ff   <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  now_ff   <= req_bus.elapsed_us;
                  count_ff <= req_count;
                  known_ff <= !req_bus.byte_count[CNT_IN_W-1];
                  fin_ff   <= req_bus.is_final;
               end
            end
            S_PREP: begin
               hold_ff  <= hold_cmp;
               delta_ff <= (known_ff && (count_ff >= last_bytes_ff)) ?
                           (count_ff - last_bytes_ff) : '0;
               if (known_ff) last_bytes_ff <= count_ff;
            end
            S_RATE: begin
               if (hold_ff) begin
                  pending_ff <= pend_sum[BYTE_W] ? BYTE_MAX : pend_sum[BYTE_W-1:0];
               end else begin
                  last_time_ff <= now_ff;
                  pending_ff   <= '0;
               end
            end
            S_MDIV: begin
               if (div_sts.done) begin
                  last_rate_ff <= rate_q;
                  meas_ff      <= meas_q;
                  sq_idx_ff    <= 2'd0;
                  if ((samples_ff == '0) || (meas_q < min_ff)) min_ff <= meas_q;
                  if (meas_q > max_ff) max_ff <= meas_q;
                  sum_ff <= sat_add64(sum_ff, SUM_W'(meas_q));
                  if (samples_ff != SAMP_MAX) samples_ff <= samples_ff + 1'b1;
               end
            end
            S_SQ: begin
               mult_ff   <= sq_a * sq_b;
               acc_ff    <= acc_sum;
               sq_idx_ff <= sq_idx_ff + 1'b1;
               if (sq_idx_ff == 2'd3) sqsum_ff <= sat_add64(sqsum_ff, sq_term);
            end
            S_WIN: begin
               if (!win_skip) begin
                  tail_ff <= tail_n;
                  head_ff <= head_n;
                  if (head_n == tail_n) avg_held_ff <= last_rate_ff;
               end
            end
            S_WHEAD: begin
               if (win_bad) avg_held_ff <= '0;
            end
            S_WDIV: begin
               if (div_sts.done) avg_held_ff <= rate_q;
            end
            S_FIN: begin
               if (fin_ff) begin
                  rate_out_ff <= '0;
                  avg_out_ff  <= '0;
               end else begin
                  rate_out_ff <= last_rate_ff;
                  avg_out_ff  <= avg_held_ff;
               end
            end
            S_FDIV: begin
               if (div_sts.done) begin
                  rate_out_ff <= rate_q;
                  avg_out_ff  <= rate_q;
               end
            end
            S_PCT: begin
               if (total_ff == '0) begin
                  pct_held_ff <= (pct_wrap_next > PCT_CAP) ? PCT_CAP : pct_wrap_next;
               end else if (!known_ff) begin
                  pct_held_ff <= '0;
               end
            end
            S_PDIV: begin
               if (div_sts.done) begin
                  pct_held_ff <= (div_sts.quotient > DIV_N_W'(PCT_CAP)) ?
                                 PCT_CAP : div_sts.quotient[PCT_W-1:0];
               end
            end
            S_DONE: ;
            default: ;
         endcase
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_DONE) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_DONE) && rsp_free) begin
         o_rate_ff    <= rate_out_ff;
         o_avg_ff     <= avg_out_ff;
         o_pct_ff     <= pct_held_ff;
         o_min_ff     <= min_ff;
         o_max_ff     <= max_ff;
         o_sum_ff     <= sum_ff;
         o_sqsum_ff   <= sqsum_ff;
         o_samples_ff <= samples_ff;
      end
   end

   assign req_bus.ready             = (state_ff == S_IDLE);
   assign csr_bus.ready             = 1'b1;
   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.current_rate      = o_rate_ff;
   assign rsp_bus.window_rate       = o_avg_ff;
   assign rsp_bus.percent_done      = o_pct_ff;
   assign rsp_bus.min_rate          = o_min_ff;
   assign rsp_bus.max_rate          = o_max_ff;
   assign rsp_bus.rate_total        = o_sum_ff;
   assign rsp_bus.rate_square_total = o_sqsum_ff;
   assign rsp_bus.sample_count      = o_samples_ff;

   // Checks
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_sts.busy)
      else $error("divider started while busy");

   a_ring_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= RING_AW'(HISTORY_DEPTH - 1)) && (tail_ff <= RING_AW'(HISTORY_DEPTH - 1)))
      else $error("ring pointer out of range");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (samples_ff != '0) |-> (min_ff <= max_ff))
      else $error("minimum rate above maximum");

   a_pct_capped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (pct_held_ff <= PCT_CAP))
      else $error("percentage above cap");

endmodule

`default_nettype wire
